FILE: src/triangle_normal_area_side_top_macros.svh
// Assertion macros for the triangle normal/area block.
`ifndef TRIANGLE_NORMAL_AREA_SIDE_TOP_MACROS_SVH
`define TRIANGLE_NORMAL_AREA_SIDE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TNAS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tnas assertion failed");
`define TNAS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tnas assertion failed");
`else
`define TNAS_ASSERT_NOW(lbl, ante, cons)
`define TNAS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/tnas_pkg.sv
package tnas_pkg;
	localparam int CB   = 16;
	localparam int FB   = 14;
	localparam int NI   = 3;
	localparam int DB   = CB + 1;
	localparam int PB   = 2 * DB;
	localparam int NB   = PB + 1;
	localparam int MB   = NB - 1;
	localparam int SQB  = 2 * MB;
	localparam int SB   = SQB + 2;
	localparam int RB   = 2 * CB + 2;
	localparam int NOB  = FB + 2;
	localparam int EB   = SB + 2 * FB + 3;
	localparam int QB   = SB + FB + 3;
	localparam int CW   = SB + 2 * FB + 5;
	localparam int PDB  = DB + MB;
	localparam int DOTB = PDB + 3;
	localparam int NSTG = (RB > FB + 1) ? RB : FB + 1;

	typedef struct packed {
		logic signed [CB-1:0] a_x;
		logic signed [CB-1:0] a_y;
		logic signed [CB-1:0] a_z;
		logic signed [CB-1:0] b_x;
		logic signed [CB-1:0] b_y;
		logic signed [CB-1:0] b_z;
		logic signed [CB-1:0] c_x;
		logic signed [CB-1:0] c_y;
		logic signed [CB-1:0] c_z;
		logic signed [CB-1:0] query_x;
		logic signed [CB-1:0] query_y;
		logic signed [CB-1:0] query_z;
	} in_t;

	typedef struct packed {
		logic signed [NOB-1:0] normal_x;
		logic signed [NOB-1:0] normal_y;
		logic signed [NOB-1:0] normal_z;
		logic [RB-1:0]         double_area;
		logic                  above;
		logic                  degenerate;
	} out_t;

	// State carried through the square-root / normalization stages.
	typedef struct packed {
		logic [SB-1:0]            s;
		logic [SB-1:0]            rem;
		logic [RB-1:0]            root;
		logic [NI-1:0][EB-1:0]    e;
		logic [NI-1:0][QB-1:0]    q;
		logic [NI-1:0][FB:0]      t;
		logic [NI-1:0]            neg;
		logic                     above;
		logic                     degen;
	} it_t;
endpackage

FILE: src/tnas_front.sv
module tnas_front import tnas_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  in_t  in_data,
	output logic valid,
	output it_t  it
);
	logic signed [DB-1:0] e1_s1 [NI];
	logic signed [DB-1:0] e2_s1 [NI];
	logic signed [DB-1:0] d_s1 [NI];
	logic signed [PB-1:0] p_s2 [2*NI];
	logic signed [DB-1:0] d_s2 [NI];
	logic signed [NB-1:0] n_s3 [NI];
	logic signed [DB-1:0] d_s3 [NI];
	logic [MB-1:0]        m_s4 [NI];
	logic [DB-1:0]        dm_s4 [NI];
	logic [NI-1:0]        sn_s4, ng_s4;
	logic [SQB-1:0]       sq_s5 [NI];
	logic [PDB-1:0]       pd_s5 [NI];
	logic [NI-1:0]        sn_s5, ng_s5;
	logic [SQB-1:0]       sq_s6 [NI];
	logic [SB-1:0]        s_s6;
	logic                 above_s6;
	logic [NI-1:0]        sn_s6;
	logic [6:0]           v_q;

	logic signed [DB-1:0]   av [NI], bv [NI], cv [NI], qv [NI];
	logic signed [NB-1:0]   nneg [NI];
	logic signed [DB-1:0]   dneg [NI];
	logic signed [DOTB-1:0] dot;
	logic [SB-1:0]          ssum;

	always_comb begin
		av[0] = DB'(in_data.a_x); av[1] = DB'(in_data.a_y); av[2] = DB'(in_data.a_z);
		bv[0] = DB'(in_data.b_x); bv[1] = DB'(in_data.b_y); bv[2] = DB'(in_data.b_z);
		cv[0] = DB'(in_data.c_x); cv[1] = DB'(in_data.c_y); cv[2] = DB'(in_data.c_z);
		qv[0] = DB'(in_data.query_x);
		qv[1] = DB'(in_data.query_y);
		qv[2] = DB'(in_data.query_z);
		for (int i = 0; i < NI; i++) begin
			nneg[i] = -n_s3[i];
			dneg[i] = -d_s3[i];
		end
		dot  = '0;
		ssum = '0;
		for (int i = 0; i < NI; i++) begin
			if (ng_s5[i]) begin
				dot = dot - DOTB'(pd_s5[i]);
			end else begin
				dot = dot + DOTB'(pd_s5[i]);
			end
			ssum = ssum + SB'(sq_s5[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NI; i++) begin
				e1_s1[i] <= bv[i] - av[i];
				e2_s1[i] <= cv[i] - av[i];
				d_s1[i]  <= qv[i] - av[i];
			end
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
			d_s2 <= d_s1;
			for (int i = 0; i < NI; i++) begin
				n_s3[i] <= NB'(p_s2[2*i]) - NB'(p_s2[2*i+1]);
			end
			d_s3 <= d_s2;
			for (int i = 0; i < NI; i++) begin
				m_s4[i]  <= n_s3[i][NB-1] ? nneg[i][MB-1:0] : n_s3[i][MB-1:0];
				dm_s4[i] <= d_s3[i][DB-1] ? dneg[i] : d_s3[i];
				sn_s4[i] <= n_s3[i][NB-1];
				ng_s4[i] <= n_s3[i][NB-1] ^ d_s3[i][DB-1];
			end
			for (int i = 0; i < NI; i++) begin
				sq_s5[i] <= m_s4[i] * m_s4[i];
				pd_s5[i] <= PDB'(dm_s4[i]) * PDB'(m_s4[i]);
			end
			sn_s5 <= sn_s4;
			ng_s5 <= ng_s4;
			sq_s6    <= sq_s5;
			s_s6     <= ssum;
			above_s6 <= (dot > 0);
			sn_s6    <= sn_s5;
			// Initial state: e = x^2 * 4^(F+1) - s, q = 4*t*s - 2*s with t = 0.
			for (int i = 0; i < NI; i++) begin
				it.e[i] <= EB'({sq_s6[i], {(2*FB+2){1'b0}}}) - EB'(s_s6);
				it.q[i] <= -(QB'(s_s6) << 1);
				it.t[i] <= '0;
			end
			it.s     <= s_s6;
			it.rem   <= s_s6;
			it.root  <= '0;
			it.neg   <= sn_s6;
			it.above <= above_s6;
			it.degen <= (s_s6 == '0);
		end
	end

	assign valid = v_q[6];
endmodule

FILE: src/triangle_normal_area_side_top.sv
// Triangle unit normal, doubled area and side test. Each transfer in carries
// three corners and a query point; each transfer out carries the Q1.14 unit
// normal, floor of the cross-product length, the strict above-plane flag and
// a degenerate flag (zero normal and area when the corners are collinear).
// One item is taken per cycle unless a result waits at the output. There are 7
// front stages (edges, cross product, magnitudes, squares, sums), 34 stages
// that each resolve one bit of the square root, the first 15 of them also one
// bit of each normal component, and the output register. The whole pipeline
// holds while a result waits at the output.
`include "triangle_normal_area_side_top_macros.svh"
module triangle_normal_area_side_top import tnas_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);
	logic en;
	it_t  iter_s [NSTG+1];
	logic v_s [NSTG+1];
	logic out_valid_q;
	out_t out_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	tnas_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.in_data (in_data),
		.valid   (v_s[0]),
		.it      (iter_s[0])
	);

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		it_t                  nxt;
		logic [SB:0]          trial;
		logic signed [CW-1:0] ew [NI];
		logic signed [CW-1:0] dw [NI];
		logic signed [CW-1:0] gw;

		always_comb begin
			nxt   = iter_s[k];
			trial = '0;
			gw    = '0;
			for (int i = 0; i < NI; i++) begin
				ew[i] = '0;
				dw[i] = '0;
			end
			if (k < RB) begin
				trial = ({1'b0, {(SB-RB){1'b0}}, iter_s[k].root} << (RB - k))
					+ ((SB+1)'(1) << (2 * (RB - 1 - k)));
				if ({1'b0, iter_s[k].rem} >= trial) begin
					nxt.rem = iter_s[k].rem - trial[SB-1:0];
					nxt.root[(RB-1-k) % RB] = 1'b1;
				end
			end
			if (k <= FB) begin
				// Accept bit b when (2t'-1)^2 * s still fits under x^2 * 4^(F+1).
				gw = $signed({{(CW-SB){1'b0}}, iter_s[k].s}) <<< (FB - k + 1);
				for (int i = 0; i < NI; i++) begin
					ew[i] = {{(CW-EB){iter_s[k].e[i][EB-1]}}, iter_s[k].e[i]};
					dw[i] = ($signed({{(CW-QB){iter_s[k].q[i][QB-1]}}, iter_s[k].q[i]})
						+ gw) <<< (FB - k + 1);
					if (!iter_s[k].t[i][FB] && (ew[i] >= dw[i])) begin
						nxt.e[i] = EB'(ew[i] - dw[i]);
						nxt.q[i] = iter_s[k].q[i] + (QB'(iter_s[k].s) << (FB - k + 2));
						nxt.t[i][(FB-k) % (FB+1)] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				iter_s[k+1] <= nxt;
			end
		end
	end

	logic [NOB-1:0] mag [NI];
	logic [NOB-1:0] nv [NI];

	always_comb begin
		for (int i = 0; i < NI; i++) begin
			mag[i] = {1'b0, iter_s[NSTG].t[i]};
			nv[i]  = iter_s[NSTG].degen ? '0 : (iter_s[NSTG].neg[i] ? -mag[i] : mag[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.normal_x    <= nv[0];
			out_q.normal_y    <= nv[1];
			out_q.normal_z    <= nv[2];
			out_q.double_area <= iter_s[NSTG].root;
			out_q.above       <= iter_s[NSTG].above && !iter_s[NSTG].degen;
			out_q.degenerate  <= iter_s[NSTG].degen;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`TNAS_ASSERT_NOW(a_degen_zero, out_valid && out_data.degenerate,
		out_data.double_area == '0 && out_data.normal_x == '0 && !out_data.above)
	`TNAS_ASSERT_NOW(a_area_nonzero, out_valid && !out_data.degenerate,
		out_data.double_area != '0)
	`TNAS_ASSERT_NOW(a_normal_nonzero, out_valid && !out_data.degenerate,
		out_data.normal_x != '0 || out_data.normal_y != '0 || out_data.normal_z != '0)
	`TNAS_ASSERT_NEXT(a_last_to_out, en && v_s[NSTG], out_valid)
endmodule
